// File: rtl/core/csp_pkg.sv
`timescale 1ns / 1ps
package csp_pkg;

  localparam int CountW   = 16;
  localparam int DeltaW   = 15;
  localparam int LenW     = 8;
  localparam int SumW     = 16;
  localparam int NumW     = DeltaW + LenW;
  localparam int QuoW     = 8;
  localparam int PosW     = 8;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int SubCntW  = $clog2(CountW);
  localparam int DivCntW  = $clog2(QuoW);

  localparam logic [LenW-1:0]   SliderUnits  = 8'd40;
  localparam logic [CountW-1:0] LowLimitRst  = 16'd10;
  localparam logic [CountW-1:0] HighLimitRst = 16'd100;

  typedef enum logic [2:0] {
    REG_BASE0  = 3'd0,
    REG_BASE1  = 3'd1,
    REG_LOW0   = 3'd2,
    REG_HIGH0  = 3'd3,
    REG_LOW1   = 3'd4,
    REG_HIGH1  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CountW-1:0] baseline0;
    logic [CountW-1:0] baseline1;
    logic [CountW-1:0] low0;
    logic [CountW-1:0] high0;
    logic [CountW-1:0] low1;
    logic [CountW-1:0] high1;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUB  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

// File: rtl/core/csp_in_if.sv
`timescale 1ns / 1ps
interface csp_in_if;
  logic                        valid;
  logic                        ready;
  logic [csp_pkg::CountW-1:0]  scan_count;

  modport source (output valid, output scan_count, input ready);
  modport sink   (input valid, input scan_count, output ready);
endinterface

// File: rtl/core/csp_out_if.sv
`timescale 1ns / 1ps
interface csp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        scanned_electrode;
  logic                        next_electrode;
  logic [csp_pkg::DeltaW-1:0]  electrode_delta;
  logic                        touched;
  logic [csp_pkg::PosW-1:0]    position;

  modport source (output valid, output scanned_electrode, output next_electrode,
                  output electrode_delta, output touched, output position,
                  input ready);
  modport sink   (input valid, input scanned_electrode, input next_electrode,
                  input electrode_delta, input touched, input position,
                  output ready);
endinterface

// File: rtl/core/capacitive_slider_position.sv
`timescale 1ns / 1ps
// a new request is accepted only in the idle state, once the previous result has been
//   loaded into the output register, so it waits on the bit-serial baseline subtract
//   and the 8-step serial dividers
// reset (rst_n, synchronous, active low): both deltas cleared, electrode 0 next,
//   registers at their reset values, output channel empty
module capacitive_slider_position (
  input  logic                       clk,
  input  logic                       rst_n,
  csp_in_if.sink                     in_ch,
  csp_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csp_pkg::AddrW-1:0]  paddr,
  input  logic [csp_pkg::DataW-1:0]  pwdata,
  output logic [csp_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  csp_pkg::cfg_t               cfg;
  csp_pkg::state_t             state_r;
  csp_pkg::state_t             state_nxt;
  logic                        cur_e_r;
  logic                        scan_e_r;
  logic [csp_pkg::DeltaW-1:0]  delta_r [2];
  logic                        touched_r;
  logic                        accept;
  logic                        sub_done;
  logic [csp_pkg::CountW-1:0]  sub_diff;
  logic [csp_pkg::DeltaW-1:0]  delta_new;
  logic                        touched;
  logic [csp_pkg::SumW-1:0]    sum;
  logic [csp_pkg::NumW-1:0]    num0;
  logic [csp_pkg::NumW-1:0]    num1;
  logic                        div_start;
  logic                        div0_done;
  logic                        div1_done;
  logic [csp_pkg::QuoW-1:0]    quo0;
  logic [csp_pkg::QuoW-1:0]    quo1;
  logic [csp_pkg::QuoW:0]      pos_sum;
  logic                        out_load;
  logic                        out_valid_r;
  logic                        out_e_r;
  logic [csp_pkg::DeltaW-1:0]  out_delta_r;
  logic                        out_touched_r;
  logic [csp_pkg::PosW-1:0]    out_pos_r;

  csp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = (state_r == csp_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  csp_sersub u_sub (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .a     (in_ch.scan_count),
    .b     (cur_e_r ? cfg.baseline1 : cfg.baseline0),
    .done  (sub_done),
    .diff  (sub_diff)
  );

  // positive as signed keeps the value, otherwise zero
  assign delta_new = (sub_diff != '0 && !sub_diff[csp_pkg::CountW-1])
                     ? sub_diff[csp_pkg::DeltaW-1:0] : '0;

  assign touched = (csp_pkg::CountW'(delta_r[0]) > cfg.high0 &&
                    csp_pkg::CountW'(delta_r[1]) > cfg.low1) ||
                   (csp_pkg::CountW'(delta_r[1]) > cfg.high1 &&
                    csp_pkg::CountW'(delta_r[0]) > cfg.low0);
  assign sum  = csp_pkg::SumW'(delta_r[0]) + csp_pkg::SumW'(delta_r[1]);
  assign num0 = csp_pkg::NumW'(delta_r[0]) * csp_pkg::NumW'(csp_pkg::SliderUnits);
  assign num1 = csp_pkg::NumW'(delta_r[1]) * csp_pkg::NumW'(csp_pkg::SliderUnits);
  assign div_start = (state_r == csp_pkg::ST_MUL);

  csp_div u_div0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num0),
    .den   (sum),
    .done  (div0_done),
    .quo   (quo0)
  );

  csp_div u_div1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num1),
    .den   (sum),
    .done  (div1_done),
    .quo   (quo1)
  );

  assign pos_sum  = ({1'b0, csp_pkg::SliderUnits} - {1'b0, quo0}) + {1'b0, quo1};
  assign out_load = (state_r == csp_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csp_pkg::ST_IDLE: if (accept)    state_nxt = csp_pkg::ST_SUB;
      csp_pkg::ST_SUB:  if (sub_done)  state_nxt = csp_pkg::ST_MUL;
      csp_pkg::ST_MUL:                 state_nxt = csp_pkg::ST_DIV;
      csp_pkg::ST_DIV:  if (div0_done) state_nxt = csp_pkg::ST_DONE;
      csp_pkg::ST_DONE: if (out_load)  state_nxt = csp_pkg::ST_IDLE;
      default:                         state_nxt = csp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csp_pkg::ST_IDLE;
      cur_e_r     <= 1'b0;
      delta_r[0]  <= '0;
      delta_r[1]  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == csp_pkg::ST_SUB && sub_done) begin
        delta_r[cur_e_r] <= delta_new;
        cur_e_r          <= ~cur_e_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_e_r <= cur_e_r;
    end
    if (state_r == csp_pkg::ST_MUL) begin
      touched_r <= touched;
    end
    if (out_load) begin
      out_e_r       <= scan_e_r;
      out_delta_r   <= delta_r[scan_e_r];
      out_touched_r <= touched_r;
      out_pos_r     <= touched_r ? pos_sum[csp_pkg::QuoW:1] : '0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.scanned_electrode = out_e_r;
  assign out_ch.next_electrode    = ~out_e_r;
  assign out_ch.electrode_delta   = out_delta_r;
  assign out_ch.touched           = out_touched_r;
  assign out_ch.position          = out_pos_r;

  a_pos_zero_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.touched || out_ch.position == '0))
    else $error("position set without a touch");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.position <= csp_pkg::SliderUnits))
    else $error("position beyond slider length");

  a_dividers_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    div0_done == div1_done)
    else $error("dividers out of step");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == csp_pkg::ST_IDLE && out_valid_r))
    else $error("result load did not complete");

endmodule

// File: rtl/core/csp_regs.sv
`timescale 1ns / 1ps
module csp_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csp_pkg::AddrW-1:0]  paddr,
  input  logic [csp_pkg::DataW-1:0]  pwdata,
  output logic [csp_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output csp_pkg::cfg_t              cfg
);

  csp_pkg::cfg_t     cfg_r;
  csp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = csp_pkg::reg_idx_t'(paddr[csp_pkg::AddrW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline0 <= '0;
      cfg_r.baseline1 <= '0;
      cfg_r.low0      <= csp_pkg::LowLimitRst;
      cfg_r.high0     <= csp_pkg::HighLimitRst;
      cfg_r.low1      <= csp_pkg::LowLimitRst;
      cfg_r.high1     <= csp_pkg::HighLimitRst;
    end else if (wr_en) begin
      unique case (idx)
        csp_pkg::REG_BASE0: cfg_r.baseline0 <= pwdata[csp_pkg::CountW-1:0];
        csp_pkg::REG_BASE1: cfg_r.baseline1 <= pwdata[csp_pkg::CountW-1:0];
        csp_pkg::REG_LOW0:  cfg_r.low0      <= pwdata[csp_pkg::CountW-1:0];
        csp_pkg::REG_HIGH0: cfg_r.high0     <= pwdata[csp_pkg::CountW-1:0];
        csp_pkg::REG_LOW1:  cfg_r.low1      <= pwdata[csp_pkg::CountW-1:0];
        csp_pkg::REG_HIGH1: cfg_r.high1     <= pwdata[csp_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      csp_pkg::REG_BASE0: prdata = csp_pkg::DataW'(cfg_r.baseline0);
      csp_pkg::REG_BASE1: prdata = csp_pkg::DataW'(cfg_r.baseline1);
      csp_pkg::REG_LOW0:  prdata = csp_pkg::DataW'(cfg_r.low0);
      csp_pkg::REG_HIGH0: prdata = csp_pkg::DataW'(cfg_r.high0);
      csp_pkg::REG_LOW1:  prdata = csp_pkg::DataW'(cfg_r.low1);
      csp_pkg::REG_HIGH1: prdata = csp_pkg::DataW'(cfg_r.high1);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/csp_sersub.sv
`timescale 1ns / 1ps
module csp_sersub (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [csp_pkg::CountW-1:0]  a,
  input  logic [csp_pkg::CountW-1:0]  b,
  output logic                        done,
  output logic [csp_pkg::CountW-1:0]  diff
);

  logic                         busy_r;
  logic                         done_r;
  logic [csp_pkg::SubCntW-1:0]  cnt_r;
  logic [csp_pkg::CountW-1:0]   a_r;
  logic [csp_pkg::CountW-1:0]   b_r;
  logic [csp_pkg::CountW-1:0]   diff_r;
  logic                         borrow_r;
  logic                         dbit;
  logic                         bout;

  // one bit per cycle, lsb first
  assign dbit = a_r[0] ^ b_r[0] ^ borrow_r;
  assign bout = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & borrow_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == csp_pkg::SubCntW'(csp_pkg::CountW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r      <= a;
      b_r      <= b;
      borrow_r <= 1'b0;
      cnt_r    <= '0;
    end else if (busy_r) begin
      a_r      <= a_r >> 1;
      b_r      <= b_r >> 1;
      diff_r   <= {dbit, diff_r[csp_pkg::CountW-1:1]};
      borrow_r <= bout;
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign diff = diff_r;

endmodule

// File: rtl/core/csp_div.sv
`timescale 1ns / 1ps
module csp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [csp_pkg::NumW-1:0]   num,
  input  logic [csp_pkg::SumW-1:0]   den,
  output logic                       done,
  output logic [csp_pkg::QuoW-1:0]   quo
);

  logic                         busy_r;
  logic                         done_r;
  logic [csp_pkg::DivCntW-1:0]  cnt_r;
  logic [csp_pkg::SumW-1:0]     rem_r;
  logic [csp_pkg::QuoW-1:0]     num_r;
  logic [csp_pkg::SumW-1:0]     den_r;
  logic [csp_pkg::QuoW-1:0]     quo_r;
  logic [csp_pkg::SumW:0]       trial;
  logic [csp_pkg::SumW:0]       less;
  logic                         fits;

  // restoring division, one quotient bit per cycle; upper dividend bits stay below den
  assign trial = {rem_r, num_r[csp_pkg::QuoW-1]};
  assign less  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == csp_pkg::DivCntW'(csp_pkg::QuoW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= csp_pkg::SumW'(num[csp_pkg::NumW-1:csp_pkg::QuoW]);
      num_r <= num[csp_pkg::QuoW-1:0];
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? less[csp_pkg::SumW-1:0] : trial[csp_pkg::SumW-1:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[csp_pkg::QuoW-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
